// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers shared by the allocator RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define BBA_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent implies consequent in the next cycle.
`define BBA_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

// Expression must never hold.
`define BBA_ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
        else $error(msg);

`endif

// ===== rtl/bba_pkg.sv =====
// ----------------------------------------------------------------------------
// bba_pkg
// Types, codes and helper functions of the bitmap block allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package bba_pkg;

    // Map geometry
    localparam int MAX_BLOCKS = 4096;
    localparam int WORD_BITS  = 32;
    localparam int MAP_WORDS  = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
    localparam int BLK_W      = $clog2(MAX_BLOCKS);
    localparam int BIT_W      = $clog2(WORD_BITS);
    localparam int WIDX_W     = $clog2(MAP_WORDS);
    localparam int CNT_W      = 13;

    localparam logic [WIDX_W-1:0] ROW_LAST  = WIDX_W'(MAP_WORDS - 1);
    localparam logic [CNT_W-1:0]  CNT_MAX   = CNT_W'(MAX_BLOCKS);

    // Action codes
    localparam logic [1:0] ACT_ALLOC  = 2'd0;
    localparam logic [1:0] ACT_FREE   = 2'd1;
    localparam logic [1:0] ACT_FORMAT = 2'd2;

    // Status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    // Register indexes
    localparam logic REG_TOTAL    = 1'b0;
    localparam logic REG_RESERVED = 1'b1;

    typedef logic [WORD_BITS-1:0] map_word_t;

    typedef struct packed {
        logic [1:0]       action;
        logic [BLK_W-1:0] block_number;
    } in_beat_t;

    typedef struct packed {
        logic [BLK_W-1:0] allocated_block;
        logic [1:0]       status;
    } out_beat_t;

    // Index of the lowest clear bit (word must not be all ones).
    function automatic logic [BIT_W-1:0] first_zero(input map_word_t word);
        logic [BIT_W-1:0] idx;
        idx = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (!word[i]) begin
                idx = BIT_W'(i);
            end
        end
        return idx;
    endfunction

    // Contents of one map word right after a format with n reserved blocks.
    function automatic map_word_t format_word(input logic [CNT_W-1:0] n,
                                              input logic [WIDX_W-1:0] row);
        logic [CNT_W-BIT_W-1:0] n_row;
        map_word_t              w;
        n_row = n[CNT_W-1:BIT_W];
        if (n_row > (CNT_W-BIT_W)'(row)) begin
            w = '1;
        end else if (n_row == (CNT_W-BIT_W)'(row)) begin
            w = (map_word_t'(1) << n[BIT_W-1:0]) - map_word_t'(1);
        end else begin
            w = '0;
        end
        return w;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/bitmap_block_allocator.sv =====
// ----------------------------------------------------------------------------
// bitmap_block_allocator
// First-fit free-block bitmap allocator with an APB register port.
// ----------------------------------------------------------------------------
// One usage bit per block, 32 blocks to a word, in a 128 x 32 single-port-read
// RAM with a registered read. Items are handled one at a time. Allocate scans
// the map one word per cycle through the RAM read port, from the first word up
// to the first word with a clear bit or to the last word. Free reads the word,
// then writes it back. Format writes the map word by word after the accepting
// cycle. An out-of-range free or an undefined action answers without a map
// access. A finished result sits in an output register, so the next beat can
// be taken as soon as the result has a slot.
// The map reads as all free after reset through per-word valid flops; there is
// no clearing pass. Registers: 0x0 total_blocks, 0x4 reserved_blocks.
// ----------------------------------------------------------------------------
`default_nettype none

module bitmap_block_allocator (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // APB register port
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [2:0]            paddr,
    input  wire logic [31:0]           pwdata,
    output logic      [31:0]           prdata,
    output logic                       pready,
    // request channel
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire bba_pkg::in_beat_t     s_data,
    // result channel
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output bba_pkg::out_beat_t         m_data
);
    import bba_pkg::*;

    `include "assert_macros.svh"

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_FREE = 2'd2;
    localparam logic [1:0] S_FMT  = 2'd3;

    // Registers
    logic [CNT_W-1:0]  total_reg;
    logic [CNT_W-1:0]  reserved_reg;
    logic [1:0]        state_reg, state_next;
    logic [WIDX_W-1:0] scan_reg, scan_next;
    logic [WIDX_W-1:0] fmt_reg, fmt_next;
    logic [BLK_W-1:0]  blk_reg, blk_next;
    logic              m_valid_reg;
    out_beat_t         m_beat_reg;

    // Map RAM
    map_word_t         usage_mem [MAP_WORDS];
    logic [MAP_WORDS-1:0] row_vld_reg;
    map_word_t         rd_data_reg;
    logic              rd_vld_reg;
    logic              mem_re, mem_we;
    logic [WIDX_W-1:0] mem_raddr, mem_waddr;
    map_word_t         mem_wdata;

    logic              s_accept;
    logic              cfg_wr;
    logic [CNT_W-1:0]  lim;
    logic [CNT_W-1:0]  fmt_n;
    map_word_t         word;
    logic [BIT_W-1:0]  zero_idx;
    logic [BLK_W-1:0]  cand;
    logic              done;
    out_beat_t         done_beat;

    // Register port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == REG_RESERVED) ? 32'(reserved_reg) : 32'(total_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_reg    <= CNT_MAX;
            reserved_reg <= '0;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_TOTAL) begin
                total_reg <= pwdata[CNT_W-1:0];
            end else begin
                reserved_reg <= pwdata[CNT_W-1:0];
            end
        end
    end

    // Limits in force
    assign lim   = (total_reg > CNT_MAX) ? CNT_MAX : total_reg;
    assign fmt_n = (reserved_reg > CNT_MAX) ? CNT_MAX : reserved_reg;

    // Word read back from the map; unwritten rows read as free
    assign word     = rd_vld_reg ? rd_data_reg : '0;
    assign zero_idx = first_zero(word);
    assign cand     = {scan_reg, zero_idx};

    assign s_ready  = (state_reg == S_IDLE) && (!m_valid_reg || m_ready);
    assign s_accept = s_valid && s_ready;

    // Sequencer
    always_comb begin
        state_next = state_reg;
        scan_next  = scan_reg;
        fmt_next   = fmt_reg;
        blk_next   = blk_reg;
        mem_re     = 1'b0;
        mem_raddr  = scan_reg + 1'b1;
        mem_we     = 1'b0;
        mem_waddr  = scan_reg;
        mem_wdata  = word;
        done       = 1'b0;
        done_beat  = '{allocated_block: '0, status: ST_OK};

        unique case (state_reg)
            S_IDLE: begin
                if (s_accept) begin
                    unique case (s_data.action)
                        ACT_ALLOC: begin
                            mem_re     = 1'b1;
                            mem_raddr  = '0;
                            scan_next  = '0;
                            state_next = S_SCAN;
                        end
                        ACT_FREE: begin
                            if ({1'b0, s_data.block_number} >= lim) begin
                                done             = 1'b1;
                                done_beat.status = ST_RANGE;
                            end else begin
                                mem_re     = 1'b1;
                                mem_raddr  = s_data.block_number[BLK_W-1:BIT_W];
                                blk_next   = s_data.block_number;
                                state_next = S_FREE;
                            end
                        end
                        ACT_FORMAT: begin
                            fmt_next   = '0;
                            state_next = S_FMT;
                        end
                        default: begin
                            done = 1'b1;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (word != '1) begin
                    // first word with a clear bit decides the outcome
                    done       = 1'b1;
                    state_next = S_IDLE;
                    if ({1'b0, cand} < lim) begin
                        mem_we                    = 1'b1;
                        mem_waddr                 = scan_reg;
                        mem_wdata                 = word | (map_word_t'(1) << zero_idx);
                        done_beat.allocated_block = cand;
                    end else begin
                        done_beat.status = ST_FULL;
                    end
                end else if (scan_reg == ROW_LAST) begin
                    done             = 1'b1;
                    done_beat.status = ST_FULL;
                    state_next       = S_IDLE;
                end else begin
                    mem_re    = 1'b1;
                    scan_next = scan_reg + 1'b1;
                end
            end
            S_FREE: begin
                mem_we     = 1'b1;
                mem_waddr  = blk_reg[BLK_W-1:BIT_W];
                mem_wdata  = word & ~(map_word_t'(1) << blk_reg[BIT_W-1:0]);
                done       = 1'b1;
                state_next = S_IDLE;
            end
            S_FMT: begin
                mem_we    = 1'b1;
                mem_waddr = fmt_reg;
                mem_wdata = format_word(fmt_n, fmt_reg);
                if (fmt_reg == ROW_LAST) begin
                    done       = 1'b1;
                    state_next = S_IDLE;
                end else begin
                    fmt_next = fmt_reg + 1'b1;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            row_vld_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (mem_we) begin
                row_vld_reg[mem_waddr] <= 1'b1;
            end
            if (done) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        scan_reg <= scan_next;
        fmt_reg  <= fmt_next;
        blk_reg  <= blk_next;
        if (done) begin
            m_beat_reg <= done_beat;
        end
    end

    // Map RAM: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            usage_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rd_data_reg <= usage_mem[mem_raddr];
            rd_vld_reg  <= row_vld_reg[mem_raddr];
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_beat_reg;

    // Checks
    `BBA_ASSERT_NEVER(a_mem_rw_clash, aclk, aresetn, mem_we && mem_re, "map read and write in one cycle")
    `BBA_ASSERT_IMP(a_out_slot_free, aclk, aresetn, done, !(m_valid_reg && !m_ready), "result overwrites pending beat")
    `BBA_ASSERT_NEXT(a_scan_step, aclk, aresetn, (state_reg == S_SCAN) && !done, (state_reg == S_SCAN) && (scan_reg == $past(scan_reg) + 1'b1), "scan did not advance one word")

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the first-fit bitmap block allocator.
// A queue of requests feeds a valid/ready driver, and a scoreboard predicts
// every answer from its own copy of the usage map and the two limit registers.
// Registers are rewritten over the APB port between phases, while the block
// is idle. Each phase starts with a format, then in some phases fixed corner
// requests, then random allocate/free traffic aimed at the allocation frontier.
// ----------------------------------------------------------------------------

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bba_pkg::*;

    localparam logic [1:0] ACT_UNDEF = 2'd3;   // no action is defined for this code

    localparam int CYCLE_LIMIT  = 600000;
    localparam int IDLE_PCT     = 35;
    localparam int HOLD_AT      = 260;         // results seen before the long back-pressure
    localparam int HOLD_LEN     = 250;
    localparam int CALM_FROM    = 520;         // results window with no idling on either side
    localparam int CALM_TO      = 680;
    localparam int DRAIN_CYCLES = 200;

    // DUT ports
    logic        aclk    = 1'b0;
    logic        aresetn = 1'b0;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [2:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_valid = 1'b0;
    logic        s_ready;
    in_beat_t    s_data  = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    out_beat_t   m_data;

    bitmap_block_allocator dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Allocator shadow state
    bit [MAX_BLOCKS-1:0] used_map     = '0;
    logic [CNT_W-1:0]    cfg_total    = CNT_MAX;
    logic [CNT_W-1:0]    cfg_reserved = '0;

    in_beat_t  requests_pending[$];
    out_beat_t answers_due[$];

    int  requests_queued = 0;
    int  requests_taken  = 0;
    int  results_seen    = 0;
    int  errors          = 0;
    int  grants          = 0;
    int  full_answers    = 0;
    int  range_answers   = 0;
    int  phases_run      = 0;
    int  cycle_count     = 0;
    int  phase_lim       = MAX_BLOCKS;
    int  phase_base      = 0;
    int  hold_left       = 0;
    bit  hold_done       = 1'b0;
    bit  s_taken         = 1'b0;

    // Answer to one request; updates the shadow map as the block would.
    function automatic out_beat_t allocator_answer(input in_beat_t req);
        out_beat_t ans;
        int        lim;
        int        n;
        int        b;
        ans = '0;
        ans.status = ST_OK;
        lim = (int'(cfg_total) < MAX_BLOCKS) ? int'(cfg_total) : MAX_BLOCKS;
        case (req.action)
            ACT_ALLOC: begin
                // lowest clear bit of the whole map, granted only below the limit
                b = 0;
                while (b < MAX_BLOCKS && used_map[b]) begin
                    b++;
                end
                if (b < lim) begin
                    used_map[b] = 1'b1;
                    ans.allocated_block = BLK_W'(b);
                end else begin
                    ans.status = ST_FULL;
                end
            end
            ACT_FREE: begin
                if (int'(req.block_number) >= lim) begin
                    ans.status = ST_RANGE;
                end else begin
                    used_map[req.block_number] = 1'b0;
                end
            end
            ACT_FORMAT: begin
                n = (int'(cfg_reserved) < MAX_BLOCKS) ? int'(cfg_reserved) : MAX_BLOCKS;
                used_map = '0;
                for (b = 0; b < n; b++) begin
                    used_map[b] = 1'b1;
                end
            end
            default: begin
                // undefined action: map untouched, plain ok
            end
        endcase
        return ans;
    endfunction

    function automatic bit calm_stretch();
        return results_seen >= CALM_FROM && results_seen < CALM_TO;
    endfunction

    function automatic void queue_request(input logic [1:0] act, input int blk);
        in_beat_t r;
        r.action       = act;
        r.block_number = BLK_W'(blk);
        requests_pending.push_back(r);
        requests_queued++;
    endfunction

    // Random traffic: mostly allocs and frees near the frontier, some noise.
    function automatic void queue_random(input int count);
        int roll;
        int pick;
        int w;
        repeat (count) begin
            roll = $urandom_range(99);
            if (roll < 48) begin
                queue_request(ACT_ALLOC, $urandom);
            end else if (roll < 90) begin
                pick = $urandom_range(9);
                if (pick < 5) begin
                    w = phase_base - 8 + $urandom_range(71);
                    if (w < 0) begin
                        w = 0;
                    end
                    if (w > MAX_BLOCKS - 1) begin
                        w = MAX_BLOCKS - 1;
                    end
                end else if (pick < 8 && phase_lim > 0) begin
                    w = $urandom_range(phase_lim - 1);
                end else begin
                    w = $urandom_range(MAX_BLOCKS - 1);
                end
                queue_request(ACT_FREE, w);
            end else if (roll < 95) begin
                queue_request(ACT_FORMAT, $urandom);
            end else begin
                queue_request(ACT_UNDEF, $urandom);
            end
        end
    endfunction

    // Block is idle once every queued request got its answer.
    task automatic wait_idle();
        while (requests_taken != requests_queued || answers_due.size() != 0) begin
            @(negedge aclk);
        end
    endtask

    // APB write: setup cycle, then access until pready.
    task automatic reg_write(input logic idx, input int value);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= 32'(value);
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (idx == REG_TOTAL) begin
            cfg_total = CNT_W'(value);
        end else begin
            cfg_reserved = CNT_W'(value);
        end
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic open_phase(input int total, input int reserved);
        wait_idle();
        reg_write(REG_TOTAL, total);
        reg_write(REG_RESERVED, reserved);
        phase_lim  = (total < MAX_BLOCKS) ? total : MAX_BLOCKS;
        phase_base = (reserved < MAX_BLOCKS) ? reserved : MAX_BLOCKS;
        phases_run++;
        queue_request(ACT_FORMAT, 0);
    endtask

    // Request driver
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_taken) begin
            s_taken = 1'b0;
            if (requests_pending.size() != 0 &&
                (calm_stretch() || $urandom_range(99) >= IDLE_PCT)) begin
                s_data  <= requests_pending.pop_front();
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Result receiver, with one long hold-off to fill the block up
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (!hold_done && results_seen >= HOLD_AT) begin
            hold_done = 1'b1;
            hold_left = HOLD_LEN - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= calm_stretch() || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Scoreboard: check result beats, then predict accepted request beats
    always @(posedge aclk) begin : scoreboard
        out_beat_t due;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                results_seen++;
                if (answers_due.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result: block %0d status %0d",
                             $time, m_data.allocated_block, m_data.status);
                end else begin
                    due = answers_due.pop_front();
                    if (m_data.allocated_block !== due.allocated_block) begin
                        errors++;
                        $display("%0t: allocated_block expected %0d got %0d",
                                 $time, due.allocated_block, m_data.allocated_block);
                    end
                    if (m_data.status !== due.status) begin
                        errors++;
                        $display("%0t: status expected %0d got %0d",
                                 $time, due.status, m_data.status);
                    end
                end
            end
            if (s_valid && s_ready) begin
                due = allocator_answer(s_data);
                answers_due.push_back(due);
                requests_taken++;
                s_taken = 1'b1;
                if (s_data.action == ACT_ALLOC && due.status == ST_OK) begin
                    grants++;
                end
                if (due.status == ST_FULL) begin
                    full_answers++;
                end
                if (due.status == ST_RANGE) begin
                    range_answers++;
                end
            end
        end
    end

    // Run limit
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: timeout after %0d cycles, %0d answers outstanding",
                     cycle_count, answers_due.size());
            $display("tb: FAIL");
            $finish;
        end
    end

    // Stimulus
    initial begin : stimulus
        int t;
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;

        // reset settings, map all free: first fit, double free, top block, odd codes
        queue_request(ACT_ALLOC, MAX_BLOCKS - 1);
        queue_request(ACT_ALLOC, 0);
        queue_request(ACT_FREE, 0);
        queue_request(ACT_FREE, 0);
        queue_request(ACT_ALLOC, 0);
        queue_request(ACT_FREE, MAX_BLOCKS - 1);
        queue_request(ACT_ALLOC, 0);
        queue_request(ACT_UNDEF, MAX_BLOCKS - 1);
        queue_request(ACT_UNDEF, 0);
        queue_request(ACT_FORMAT, MAX_BLOCKS - 1);
        queue_request(ACT_ALLOC, 0);

        // small device: frees on both sides of the limit, fills up
        open_phase(37, 5);
        queue_request(ACT_FREE, 36);
        queue_request(ACT_FREE, 37);
        queue_request(ACT_FREE, MAX_BLOCKS - 1);
        queue_random(106);

        // single block: grant, then full
        open_phase(1, 0);
        queue_request(ACT_ALLOC, 0);
        queue_request(ACT_ALLOC, 0);
        queue_request(ACT_FREE, 0);
        queue_request(ACT_FREE, 1);
        queue_random(25);

        // zero blocks: alloc always full, every free out of range
        open_phase(0, 0);
        queue_request(ACT_ALLOC, 0);
        queue_request(ACT_FREE, 0);
        queue_random(17);

        // whole map reserved
        open_phase(MAX_BLOCKS, MAX_BLOCKS);
        queue_request(ACT_ALLOC, 0);
        queue_request(ACT_FREE, MAX_BLOCKS - 1);
        queue_request(ACT_ALLOC, 0);
        queue_random(15);

        // total past the map, frontier near the top: long scans
        open_phase(8191, 4000);
        queue_random(119);

        // reserved area larger than the device
        open_phase(100, 200);
        queue_request(ACT_ALLOC, 0);
        queue_request(ACT_FREE, 99);
        queue_request(ACT_FREE, 100);
        queue_random(56);

        open_phase(MAX_BLOCKS, 0);
        queue_random(249);

        // reserved count past the map
        open_phase(64, 8191);
        queue_request(ACT_ALLOC, 0);
        queue_request(ACT_FREE, 63);
        queue_random(37);

        t = $urandom_range(1, 300);
        open_phase(t, $urandom_range(0, t));
        queue_random(149);

        open_phase(513, 480);
        queue_random(129);

        wait_idle();
        repeat (DRAIN_CYCLES) @(negedge aclk);

        $display("tb: %0d requests in %0d register settings, %0d results checked",
                 requests_taken, phases_run + 1, results_seen);
        $display("tb: %0d grants, %0d map-full answers, %0d out-of-range frees, %0d errors",
                 grants, full_answers, range_answers, errors);
        if (errors == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/bba_pkg.sv
rtl/bitmap_block_allocator.sv
tb/tb.sv
